// ===== hw/rtl/chp_pkg.sv =====
// ----------------------------------------------------------------------------
// chp_pkg: shared types and constants for the convex hull block
// Holds the word format that passes from the front part to the back part.
// ----------------------------------------------------------------------------
package chp_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int MIN_HULL       = 3;
  localparam int QUEUE_DEPTH    = 4;

  // One queued input word, tagged by the front part
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               last;
    logic               keep;
    logic               ovf;
  } chp_item_t;

endpackage

// ===== hw/rtl/chp_front.sv =====
// ----------------------------------------------------------------------------
// chp_front: input side of the convex hull block
// Counts points of the current set, tags each word as kept or dropped and
// tracks overflow of the set.
// ----------------------------------------------------------------------------
module chp_front #(
  parameter int MaxPoints = chp_pkg::MAX_POINTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic signed [31:0]  in_point_x,
  input  logic signed [31:0]  in_point_y,
  input  logic                in_last_point,
  input  logic                q_full,
  output logic                q_push,
  output chp_pkg::chp_item_t  q_item
);
  import chp_pkg::*;

  localparam int CW = $clog2(MaxPoints + 1);

  logic [CW-1:0] cnt_r;
  logic          ovf_r;
  logic          keep;

  // Tag the incoming word
  assign keep    = cnt_r < CW'(MaxPoints);
  assign in_full = q_full;
  assign q_push  = in_push && !q_full;
  assign q_item  = '{x: in_point_x, y: in_point_y, last: in_last_point,
                     keep: keep, ovf: ovf_r || !keep};

  // Advance the set count, clear it at the end of a set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (q_push) begin
      if (in_last_point) begin
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + CW'(keep);
        ovf_r <= ovf_r || !keep;
      end
    end
  end

endmodule

// ===== hw/rtl/chp_queue.sv =====
// ----------------------------------------------------------------------------
// chp_queue: short queue between the front and back parts
// First-in first-out store of tagged words.
// ----------------------------------------------------------------------------
module chp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  chp_pkg::chp_item_t wr_item,
  output logic               full,
  input  logic               pop,
  output chp_pkg::chp_item_t rd_item,
  output logic               empty
);
  import chp_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  chp_item_t     mem_r [QUEUE_DEPTH];
  logic [AW-1:0] wp_r;
  logic [AW-1:0] rp_r;
  logic [AW:0]   cnt_r;

  assign full    = cnt_r == (AW+1)'(QUEUE_DEPTH);
  assign empty   = cnt_r == '0;
  assign rd_item = mem_r[rp_r];

  // Store the word at the write pointer
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// ===== hw/rtl/chp_back.sv =====
// ----------------------------------------------------------------------------
// chp_back: sort and hull engine of the convex hull block
// Keeps points sorted by insertion as they load, runs the monotone chain
// over a stack memory and feeds the hull vertices to an output register.
// ----------------------------------------------------------------------------
module chp_back #(
  parameter int MaxPoints = chp_pkg::MAX_POINTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  chp_pkg::chp_item_t  q_item,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output logic signed [31:0]  out_hull_x,
  output logic signed [31:0]  out_hull_y,
  output logic                out_last_vertex,
  output logic                out_points_dropped
);
  import chp_pkg::*;

  localparam int IW = $clog2(MaxPoints);
  localparam int CW = $clog2(MaxPoints + 1);
  localparam int SD = 2 * MaxPoints + 1;
  localparam int SW = $clog2(SD);

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_INS_WR, S_START, S_RDP, S_LDP, S_CHK,
    S_RSTK, S_RPT, S_MUL, S_CMP, S_ERD, S_EPT, S_EOUT, S_RAW
  } state_t;

  state_t             st_r;
  logic [CW-1:0]      n_r;
  logic [IW-1:0]      j_r;
  logic [IW-1:0]      i_r;
  logic               up_r;
  logic [SW-1:0]      top_r;
  logic [SW-1:0]      lsz_r;
  logic [SW-1:0]      e_r;
  logic signed [31:0] cur_x_r, cur_y_r;
  logic               last_r;
  logic               ovf_r;
  logic signed [31:0] p0x_r, p0y_r, p1x_r, p1y_r;
  logic signed [31:0] px_r, py_r;
  logic signed [32:0] dxb_r, dyb_r, dxp_r, dyp_r;
  logic signed [65:0] lp_r, rp_r;
  logic               out_valid_r;
  logic signed [31:0] out_x_r, out_y_r;
  logic               out_last_r, out_ovf_r;

  // Point memory, sorted by x then y
  logic [63:0]        pt_mem [MaxPoints];
  logic [63:0]        pt_rd0_r, pt_rd1_r;
  logic               pt_we;
  logic [IW-1:0]      pt_wa, pt_ra0, pt_ra1;
  logic [63:0]        pt_wd;

  // Hull stack memory of point indices
  logic [IW-1:0]      stk_mem [SD];
  logic [IW-1:0]      stk_rd0_r, stk_rd1_r;
  logic               stk_we;
  logic [SW-1:0]      stk_ra0, stk_ra1;

  logic               out_free;
  logic               gt;
  logic               need_chk;
  logic               turn_pop;
  logic               do_push;
  logic signed [31:0] ax, ay, bx, by, qx, qy;

  assign qx = pt_rd0_r[63:32];
  assign qy = pt_rd0_r[31:0];
  assign ax = pt_rd0_r[63:32];
  assign ay = pt_rd0_r[31:0];
  assign bx = pt_rd1_r[63:32];
  assign by = pt_rd1_r[31:0];

  assign out_free = !out_valid_r || out_pop;
  assign q_pop    = (st_r == S_IDLE) && !q_empty;
  assign gt       = (qx > cur_x_r) || ((qx == cur_x_r) && (qy > cur_y_r));
  assign need_chk = top_r >= (up_r ? lsz_r : SW'(2));
  assign turn_pop = lp_r <= rp_r;
  assign do_push  = ((st_r == S_CHK) && !need_chk) || ((st_r == S_CMP) && !turn_pop);

  // Point memory ports
  always_comb begin
    pt_we  = 1'b0;
    pt_wa  = j_r;
    pt_wd  = {cur_x_r, cur_y_r};
    pt_ra0 = stk_rd0_r;
    pt_ra1 = stk_rd1_r;
    unique case (st_r)
      S_INS_RD:  pt_ra0 = j_r - 1'b1;
      S_INS_CMP: begin
        pt_we = gt;
        pt_wd = pt_rd0_r;
      end
      S_INS_WR:  pt_we = 1'b1;
      S_RDP:     pt_ra0 = i_r;
      default:   pt_ra0 = stk_rd0_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[pt_wa] <= pt_wd;
    pt_rd0_r <= pt_mem[pt_ra0];
    pt_rd1_r <= pt_mem[pt_ra1];
  end

  // Stack memory ports
  assign stk_we  = do_push;
  assign stk_ra0 = (st_r == S_CHK) ? top_r - SW'(2) : e_r;
  assign stk_ra1 = top_r - 1'b1;

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[top_r] <= i_r;
    stk_rd0_r <= stk_mem[stk_ra0];
    stk_rd1_r <= stk_mem[stk_ra1];
  end

  // Cross product datapath: differences, then products
  always_ff @(posedge clk) begin
    if (st_r == S_RPT) begin
      dxb_r <= 33'(bx) - 33'(ax);
      dyb_r <= 33'(by) - 33'(ay);
      dxp_r <= 33'(px_r) - 33'(ax);
      dyp_r <= 33'(py_r) - 33'(ay);
    end
    if (st_r == S_MUL) begin
      lp_r <= dxb_r * dyp_r;
      rp_r <= dyb_r * dxp_r;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the held word on pop unless a new one loads this cycle
      if (out_pop && st_r != S_EOUT && st_r != S_RAW) out_valid_r <= 1'b0;
      if (do_push) begin
        if (up_r && i_r == '0) begin
          // Closing point repeats the first one: keep top, start emission
          e_r  <= '0;
          st_r <= S_ERD;
        end else begin
          top_r <= top_r + 1'b1;
          st_r  <= S_RDP;
          if (!up_r && i_r == IW'(n_r - CW'(1))) begin
            up_r  <= 1'b1;
            lsz_r <= top_r + SW'(2);
            i_r   <= i_r - 1'b1;
          end else if (!up_r) begin
            i_r <= i_r + 1'b1;
          end else begin
            i_r <= i_r - 1'b1;
          end
        end
      end else begin
        unique case (st_r)
          S_IDLE: begin
            if (!q_empty) begin
              cur_x_r <= q_item.x;
              cur_y_r <= q_item.y;
              last_r  <= q_item.last;
              if (q_item.last) ovf_r <= q_item.ovf;
              if (q_item.keep) begin
                if (n_r == '0) begin
                  p0x_r <= q_item.x;
                  p0y_r <= q_item.y;
                  j_r   <= '0;
                  st_r  <= S_INS_WR;
                end else begin
                  if (n_r == CW'(1)) begin
                    p1x_r <= q_item.x;
                    p1y_r <= q_item.y;
                  end
                  j_r  <= IW'(n_r);
                  st_r <= S_INS_RD;
                end
              end else if (q_item.last) begin
                st_r <= S_START;
              end
            end
          end
          S_INS_RD: st_r <= S_INS_CMP;
          S_INS_CMP: begin
            if (gt) begin
              j_r  <= j_r - 1'b1;
              st_r <= (j_r == IW'(1)) ? S_INS_WR : S_INS_RD;
            end else begin
              st_r <= S_INS_WR;
            end
          end
          S_INS_WR: begin
            n_r  <= n_r + 1'b1;
            st_r <= last_r ? S_START : S_IDLE;
          end
          S_START: begin
            e_r   <= '0;
            i_r   <= '0;
            top_r <= '0;
            up_r  <= 1'b0;
            st_r  <= (n_r < CW'(MIN_HULL)) ? S_RAW : S_RDP;
          end
          S_RDP: st_r <= S_LDP;
          S_LDP: begin
            px_r <= qx;
            py_r <= qy;
            st_r <= S_CHK;
          end
          S_CHK:  st_r <= S_RSTK;
          S_RSTK: st_r <= S_RPT;
          S_RPT:  st_r <= S_MUL;
          S_MUL:  st_r <= S_CMP;
          S_CMP: begin
            top_r <= top_r - 1'b1;
            st_r  <= S_CHK;
          end
          S_ERD: st_r <= S_EPT;
          S_EPT: st_r <= S_EOUT;
          S_EOUT: begin
            if (out_free) begin
              out_valid_r <= 1'b1;
              out_x_r     <= qx;
              out_y_r     <= qy;
              out_ovf_r   <= ovf_r;
              out_last_r  <= e_r == top_r - 1'b1;
              e_r         <= e_r + 1'b1;
              if (e_r == top_r - 1'b1) begin
                n_r  <= '0;
                st_r <= S_IDLE;
              end else begin
                st_r <= S_ERD;
              end
            end
          end
          S_RAW: begin
            if (out_free) begin
              out_valid_r <= 1'b1;
              out_x_r     <= e_r[0] ? p1x_r : p0x_r;
              out_y_r     <= e_r[0] ? p1y_r : p0y_r;
              out_ovf_r   <= ovf_r;
              out_last_r  <= e_r == SW'(n_r) - 1'b1;
              e_r         <= e_r + 1'b1;
              if (e_r == SW'(n_r) - 1'b1) begin
                n_r  <= '0;
                st_r <= S_IDLE;
              end
            end
          end
          default: st_r <= S_IDLE;
        endcase
      end
    end
  end

  assign out_empty          = !out_valid_r;
  assign out_hull_x         = out_x_r;
  assign out_hull_y         = out_y_r;
  assign out_last_vertex    = out_last_r;
  assign out_points_dropped = out_ovf_r;

endmodule

// ===== hw/rtl/convex_hull_monotone_chain.sv =====
// Loading: each point is placed in the sorted store by moving past every larger stored point.
// A set's hull pass reads each point and then checks the stack, paced by the registered
// memory reads and the two-stage cross product. Each hull vertex is then read through the
// stack and point memory ports; sets of under three points are sent straight from registers.
// Throughput: words queue 4 deep ahead of the engine; one set is worked at a time.
// Reset: synchronous, active low; clears the set count, queue and output register.
// ----------------------------------------------------------------------------
// convex_hull_monotone_chain: convex hull of a loaded point set
// Front part tags words, a short queue decouples it from the hull engine.
// ----------------------------------------------------------------------------
module convex_hull_monotone_chain #(
  parameter int MaxPoints = chp_pkg::MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic               in_last_point,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_hull_x,
  output logic signed [31:0] out_hull_y,
  output logic               out_last_vertex,
  output logic               out_points_dropped
);
  import chp_pkg::*;

  chp_item_t wr_item, rd_item;
  logic      q_push, q_full, q_pop, q_empty;

  chp_front #(.MaxPoints(MaxPoints)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_point_x, .in_point_y, .in_last_point,
    .q_full, .q_push, .q_item(wr_item)
  );

  chp_queue u_queue (
    .clk, .rst_n, .push(q_push), .wr_item, .full(q_full),
    .pop(q_pop), .rd_item, .empty(q_empty)
  );

  chp_back #(.MaxPoints(MaxPoints)) u_back (
    .clk, .rst_n, .q_item(rd_item), .q_empty, .q_pop,
    .out_empty, .out_pop, .out_hull_x, .out_hull_y, .out_last_vertex,
    .out_points_dropped
  );

endmodule
